/* src/sfh_pkg.sv */
// ----------------------------------------------------------------------------
// Symbol frequency histogram package
// Shared sizes, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package sfh_pkg;

    localparam int SYMBOL_BITS = 16;
    localparam int COUNT_BITS  = 32;
    localparam int TABLE_DEPTH = 1 << SYMBOL_BITS;

    localparam int ASM_BITS    = 16;
    localparam int VALUE_BITS  = 16;
    localparam int OUT_CNT_BITS = 32;
    localparam int DIST_BITS   = 17;
    localparam int CFG_BITS    = 2;
    localparam int ACT_BITS    = 2;

    localparam logic [ACT_BITS-1:0] ACT_DATA  = 2'd0;
    localparam logic [ACT_BITS-1:0] ACT_FLUSH = 2'd1;
    localparam logic [ACT_BITS-1:0] ACT_READ  = 2'd2;

    localparam logic [CFG_BITS-1:0] BPS_ONE = 2'd1;
    localparam logic [CFG_BITS-1:0] BPS_TWO = 2'd2;

    localparam logic KIND_UPDATE = 1'b0;
    localparam logic KIND_READ   = 1'b1;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_COUNT,
        OP_READ
    } op_t;

    typedef struct packed {
        logic clear_en;
        logic accept;
        logic update_en;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic op_none;
    } dp_status_t;

endpackage

`default_nettype wire

/* src/sfh_ctrl.sv */
// ----------------------------------------------------------------------------
// Symbol frequency histogram controller
// Sequences the table clear after reset and the lookup and update of each word.
// ----------------------------------------------------------------------------
`default_nettype none

module sfh_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire sfh_pkg::dp_status_t status,
    output sfh_pkg::ctrl_cmd_t      cmd,
    output logic                    busy
);
    import sfh_pkg::*;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_UPDATE
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                // Items that produce nothing skip the update state.
                state_next = status.op_none ? ST_IDLE : ST_UPDATE;
            end
            ST_UPDATE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy          = (state_reg != ST_IDLE);
    assign cmd.clear_en  = (state_reg == ST_CLEAR);
    assign cmd.accept    = (state_reg == ST_IDLE) && start;
    assign cmd.update_en = (state_reg == ST_UPDATE);

endmodule

`default_nettype wire

/* src/sfh_datapath.sv */
// ----------------------------------------------------------------------------
// Symbol frequency histogram datapath
// Symbol assembly, frequency table memory, saturating count and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module sfh_datapath (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire sfh_pkg::ctrl_cmd_t                  cmd,
    output sfh_pkg::dp_status_t                      status,
    input  wire logic [sfh_pkg::ACT_BITS-1:0]        action,
    input  wire logic [7:0]                          data_byte,
    input  wire logic [sfh_pkg::VALUE_BITS-1:0]      query_symbol,
    input  wire logic                                cfg_valid,
    input  wire logic [sfh_pkg::CFG_BITS-1:0]        bytes_per_symbol,
    output logic                                     result_valid,
    output logic                                     result_kind,
    output logic [sfh_pkg::VALUE_BITS-1:0]           symbol_value,
    output logic [sfh_pkg::OUT_CNT_BITS-1:0]         symbol_count,
    output logic                                     first_seen,
    output logic [sfh_pkg::DIST_BITS-1:0]            distinct_symbols
);
    import sfh_pkg::*;

    logic [CFG_BITS-1:0]    bps_reg;
    logic [ASM_BITS-1:0]    asm_reg;
    logic [ASM_BITS-1:0]    asm_next;
    logic                   phase_reg;
    logic                   phase_next;
    op_t                    op_reg;
    op_t                    op_next;
    logic [SYMBOL_BITS-1:0] sym_reg;
    logic [SYMBOL_BITS-1:0] sym_next;
    logic [SYMBOL_BITS-1:0] clr_addr_reg;
    logic [DIST_BITS-1:0]   dist_reg;
    logic [DIST_BITS-1:0]   dist_next;

    logic [COUNT_BITS-1:0]  table_mem [TABLE_DEPTH];
    logic [COUNT_BITS-1:0]  rd_data_reg;
    logic [COUNT_BITS-1:0]  new_count;
    logic                   is_first;
    logic                   do_count;
    logic                   wr_en;
    logic [SYMBOL_BITS-1:0] wr_addr;
    logic [COUNT_BITS-1:0]  wr_data;

    logic                   res_valid_reg;
    logic                   res_kind_reg;
    logic [VALUE_BITS-1:0]  res_sym_reg;
    logic [OUT_CNT_BITS-1:0] res_cnt_reg;
    logic                   res_first_reg;
    logic [DIST_BITS-1:0]   res_dist_reg;

    // Decode of an accepted word: assembly update and the table operation.
    always_comb
    begin
        asm_next   = ASM_BITS'(0);
        phase_next = 1'b0;
        op_next    = OP_NONE;
        sym_next   = SYMBOL_BITS'(data_byte);
        case (action)
            ACT_DATA:
            begin
                if (bps_reg != BPS_TWO)
                begin
                    op_next = OP_COUNT;
                end
                else if (!phase_reg)
                begin
                    asm_next   = {data_byte, 8'h00};
                    phase_next = 1'b1;
                end
                else
                begin
                    op_next  = OP_COUNT;
                    sym_next = SYMBOL_BITS'({asm_reg[ASM_BITS-1:8], data_byte});
                end
            end
            ACT_FLUSH:
            begin
                // A half-built symbol is counted unless its value is zero.
                sym_next = SYMBOL_BITS'(asm_reg);
                if (phase_reg && (asm_reg != ASM_BITS'(0)))
                begin
                    op_next = OP_COUNT;
                end
            end
            ACT_READ:
            begin
                // A read leaves a half-built symbol in place.
                asm_next   = asm_reg;
                phase_next = phase_reg;
                op_next    = OP_READ;
                sym_next   = SYMBOL_BITS'(query_symbol);
            end
            default:
            begin
                asm_next   = asm_reg;
                phase_next = phase_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bps_reg      <= BPS_ONE;
            asm_reg      <= ASM_BITS'(0);
            phase_reg    <= 1'b0;
            op_reg       <= OP_NONE;
            clr_addr_reg <= SYMBOL_BITS'(0);
            dist_reg     <= DIST_BITS'(0);
        end
        else
        begin
            if (cfg_valid)
            begin
                bps_reg   <= bytes_per_symbol;
                asm_reg   <= ASM_BITS'(0);
                phase_reg <= 1'b0;
            end
            else if (cmd.accept)
            begin
                asm_reg   <= asm_next;
                phase_reg <= phase_next;
            end
            if (cmd.accept)
            begin
                op_reg <= op_next;
            end
            if (cmd.clear_en)
            begin
                clr_addr_reg <= clr_addr_reg + SYMBOL_BITS'(1);
            end
            dist_reg <= dist_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            sym_reg <= sym_next;
        end
    end

    // Saturating increment of the looked-up count.
    assign is_first  = (rd_data_reg == COUNT_BITS'(0));
    assign new_count = (rd_data_reg == {COUNT_BITS{1'b1}}) ? rd_data_reg
                                                           : rd_data_reg + COUNT_BITS'(1);
    assign do_count  = cmd.update_en && (op_reg == OP_COUNT);

    always_comb
    begin
        dist_next = dist_reg;
        if (do_count && is_first && (dist_reg != {DIST_BITS{1'b1}}))
        begin
            dist_next = dist_reg + DIST_BITS'(1);
        end
    end

    assign wr_en   = cmd.clear_en || do_count;
    assign wr_addr = cmd.clear_en ? clr_addr_reg : sym_reg;
    assign wr_data = cmd.clear_en ? COUNT_BITS'(0) : new_count;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= table_mem[sym_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= cmd.update_en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update_en)
        begin
            res_sym_reg  <= VALUE_BITS'(sym_reg);
            res_dist_reg <= dist_next;
            if (op_reg == OP_COUNT)
            begin
                res_kind_reg  <= KIND_UPDATE;
                res_cnt_reg   <= OUT_CNT_BITS'(new_count);
                res_first_reg <= is_first;
            end
            else
            begin
                res_kind_reg  <= KIND_READ;
                res_cnt_reg   <= OUT_CNT_BITS'(rd_data_reg);
                res_first_reg <= 1'b0;
            end
        end
    end

    assign status.clear_last = (clr_addr_reg == {SYMBOL_BITS{1'b1}});
    assign status.op_none    = (op_reg == OP_NONE);

    assign result_valid     = res_valid_reg;
    assign result_kind      = res_kind_reg;
    assign symbol_value     = res_sym_reg;
    assign symbol_count     = res_cnt_reg;
    assign first_seen       = res_first_reg;
    assign distinct_symbols = res_dist_reg;

endmodule

`default_nettype wire

/* src/symbol_frequency_histogram.sv */
// ----------------------------------------------------------------------------
// Symbol frequency histogram
// Packs bytes into 8- or 16-bit symbols and keeps a saturating count per symbol.
// ----------------------------------------------------------------------------
// After reset the block clears its 65536-entry count table, one entry per
// cycle, and holds busy high until the clear is done. A word is taken when
// start is high and busy is low. A word that counts or reads a symbol keeps
// busy high through the table read and the write-back after the accepting
// edge; its result strobe appears in the cycle after the write-back, when the
// next word may already be taken. A word that only stores a first byte, or
// produces nothing, keeps busy high only through the table read. The
// configuration register is written only in a cycle where busy and start are
// both low. The single table memory limits how often words are taken: a
// registered read, then the write-back of the incremented count. Results
// cannot be stalled: each one is on the result ports for exactly one cycle
// with result_valid high.
`default_nettype none

module symbol_frequency_histogram (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic [sfh_pkg::ACT_BITS-1:0]        action,
    input  wire logic [7:0]                          data_byte,
    input  wire logic [sfh_pkg::VALUE_BITS-1:0]      query_symbol,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [sfh_pkg::CFG_BITS-1:0]        bytes_per_symbol,
    output logic                                     result_valid,
    output logic                                     result_kind,
    output logic [sfh_pkg::VALUE_BITS-1:0]           symbol_value,
    output logic [sfh_pkg::OUT_CNT_BITS-1:0]         symbol_count,
    output logic                                     first_seen,
    output logic [sfh_pkg::DIST_BITS-1:0]            distinct_symbols
);
    import sfh_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;
    logic       cfg_write;

    // A register write never meets a word in flight or one being taken.
    assign cfg_ready = !busy && !start;
    assign cfg_write = cfg_valid && cfg_ready;

    sfh_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    sfh_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .action           (action),
        .data_byte        (data_byte),
        .query_symbol     (query_symbol),
        .cfg_valid        (cfg_write),
        .bytes_per_symbol (bytes_per_symbol),
        .result_valid     (result_valid),
        .result_kind      (result_kind),
        .symbol_value     (symbol_value),
        .symbol_count     (symbol_count),
        .first_seen       (first_seen),
        .distinct_symbols (distinct_symbols)
    );

endmodule

`default_nettype wire

/* src/sfh_checker.sv */
// ----------------------------------------------------------------------------
// Symbol frequency histogram checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sfh_checker (
    input wire logic                                clk,
    input wire logic                                rst_n,
    input wire logic                                start,
    input wire logic                                busy,
    input wire logic                                result_valid,
    input wire logic                                result_kind,
    input wire logic [sfh_pkg::OUT_CNT_BITS-1:0]    symbol_count,
    input wire logic                                first_seen
);
    import sfh_pkg::*;

    // An accepted word always raises busy in the cycle after it is taken.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after a word was accepted");

    // Results come from finished table work, never back to back.
    a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("two result strobes in consecutive cycles");

    a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
        else $error("result strobe without preceding work");

    a_update_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result_kind == KIND_UPDATE)) |-> (symbol_count != '0))
        else $error("update result with zero count");

    a_first_is_one: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && first_seen) |->
            ((result_kind == KIND_UPDATE) && (symbol_count == OUT_CNT_BITS'(1))))
        else $error("first occurrence without a count of one");

endmodule

bind symbol_frequency_histogram sfh_checker u_sfh_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .result_kind  (result_kind),
    .symbol_count (symbol_count),
    .first_seen   (first_seen)
);

`default_nettype wire
